// ===== design/sacd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacd_pkg: shared types and constants
// Command codes, queue entry type, character constants and reply tables
// used by the serial actuator command decoder.
// ---------------------------------------------------------------------------
package sacd_pkg;

    localparam int BYTE_W       = 8;
    localparam int DUTY_W       = 10;
    localparam int LED_W        = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 10;
    localparam int COUNT_W      = 3;
    localparam int REPLY_IDX_W  = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int FRAME_LEN    = 4;

    // register reset values
    localparam logic [BYTE_W-1:0] START_CHAR_RESET = 8'd53;
    localparam logic [DUTY_W-1:0] RUN_DUTY_RESET   = 10'd723;
    localparam logic [DUTY_W-1:0] STOP_DUTY_RESET  = 10'h3ff;
    localparam logic [DUTY_W-1:0] DUTY_RESET       = 10'h3ff;

    // led codes
    localparam logic [LED_W-1:0] LED_RESET = 3'd1;
    localparam logic [LED_W-1:0] LED_RUN   = 3'd4;
    localparam logic [LED_W-1:0] LED_STOP  = 3'd5;

    // characters
    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3a;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7e;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_CHAR = 2'd0,
        CFG_RUN_DUTY   = 2'd1,
        CFG_STOP_DUTY  = 2'd2
    } cfg_index_t;

    // decoded frame commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_KICK_RUN,
        CMD_KICK_STOP,
        CMD_CHARGE_RUN,
        CMD_CHARGE_STOP,
        CMD_BALL_QUERY,
        CMD_DRIB_RUN,
        CMD_DRIB_STOP
    } cmd_t;

    // one closed frame handed from front to back
    typedef struct packed {
        cmd_t cmd;
        logic no_ball;
    } cmd_entry_t;

    // map two command letters to a command
    function automatic cmd_t decode_cmd(input logic [BYTE_W-1:0] a,
                                        input logic [BYTE_W-1:0] b);
        cmd_t c;
        c = CMD_NONE;
        if (a == "k" && b == "r")      c = CMD_KICK_RUN;
        else if (a == "k" && b == "s") c = CMD_KICK_STOP;
        else if (a == "c" && b == "r") c = CMD_CHARGE_RUN;
        else if (a == "c" && b == "s") c = CMD_CHARGE_STOP;
        else if (a == "i" && b == "b") c = CMD_BALL_QUERY;
        else if (a == "d" && b == "r") c = CMD_DRIB_RUN;
        else if (a == "d" && b == "s") c = CMD_DRIB_STOP;
        return c;
    endfunction

    // reply text: "yes" CR LF with a ball, "no" CR LF without
    function automatic logic [BYTE_W-1:0] reply_byte(input logic no_ball,
                                                     input logic [REPLY_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] r;
        r = CHAR_LF;
        if (no_ball) begin
            unique case (idx)
                3'd0:    r = "n";
                3'd1:    r = "o";
                3'd2:    r = CHAR_CR;
                default: r = CHAR_LF;
            endcase
        end
        else begin
            unique case (idx)
                3'd0:    r = "y";
                3'd1:    r = "e";
                3'd2:    r = "s";
                3'd3:    r = CHAR_CR;
                default: r = CHAR_LF;
            endcase
        end
        return r;
    endfunction

    // index of the final reply byte
    function automatic logic [REPLY_IDX_W-1:0] reply_last_idx(input logic no_ball);
        return no_ball ? 3'd3 : 3'd4;
    endfunction

endpackage

// ===== design/sacd_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacd_if: channel interfaces
// Receive byte channel, result channel and configuration write channel,
// each with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sacd_rx_if;
    import sacd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              ball_sensor;

    modport source (output valid, rx_byte, ball_sensor, input ready);
    modport sink   (input valid, rx_byte, ball_sensor, output ready);
endinterface

interface sacd_tx_if;
    import sacd_pkg::*;

    logic              valid;
    logic              ready;
    logic              kick_drive;
    logic              charge_drive;
    logic [LED_W-1:0]  led_select;
    logic [DUTY_W-1:0] dribbler_duty;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;

    modport source (output valid, kick_drive, charge_drive, led_select, dribbler_duty,
                    tx_valid, tx_byte, last, input ready);
    modport sink   (input valid, kick_drive, charge_drive, led_select, dribbler_duty,
                    tx_valid, tx_byte, last, output ready);
endinterface

interface sacd_cfg_if;
    import sacd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/sacd_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacd_front: frame capture and command classification
// Takes received bytes, tracks the open frame, stores its first four
// printable bytes and pushes a decoded command when the frame closes.
// ---------------------------------------------------------------------------
module sacd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    sacd_rx_if.sink                     rx,
    input  logic [sacd_pkg::BYTE_W-1:0] start_char,
    input  logic                        q_full,
    output logic                        q_push,
    output sacd_pkg::cmd_entry_t        q_entry
);
    import sacd_pkg::*;

    logic               capturing_reg, capturing_next;
    logic [COUNT_W-1:0] char_count_reg, char_count_next;
    logic [BYTE_W-1:0]  frame_chars_reg [FRAME_LEN];

    logic               accept;
    logic               is_start;
    logic               cap_eff;
    logic [COUNT_W-1:0] cnt_eff;
    logic               printable;
    logic               is_close;
    logic               store;
    logic               close;
    cmd_t               cmd;

    // byte is taken whenever the queue can hold a closing frame
    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;

    // classify the byte against the open frame
    always_comb
    begin
        is_start  = (rx.rx_byte == start_char);
        cap_eff   = is_start || capturing_reg;
        cnt_eff   = is_start ? '0 : char_count_reg;
        printable = (rx.rx_byte >= PRINT_LO) && (rx.rx_byte <= PRINT_HI);
        is_close  = (rx.rx_byte == CHAR_CR) || (rx.rx_byte == CHAR_LF);
        store     = cap_eff && printable && (cnt_eff < COUNT_W'(FRAME_LEN));
        close     = cap_eff && is_close;

        cmd = CMD_NONE;
        if (cnt_eff == COUNT_W'(FRAME_LEN) && frame_chars_reg[0] == start_char
            && frame_chars_reg[1] == CHAR_COLON)
        begin
            cmd = decode_cmd(frame_chars_reg[2], frame_chars_reg[3]);
        end

        capturing_next  = close ? 1'b0 : cap_eff;
        if (close)
        begin
            char_count_next = '0;
        end
        else if (store)
        begin
            char_count_next = cnt_eff + COUNT_W'(1);
        end
        else
        begin
            char_count_next = cnt_eff;
        end
    end

    assign q_push          = accept && close;
    assign q_entry.cmd     = cmd;
    assign q_entry.no_ball = rx.ball_sensor;

    // frame control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg  <= 1'b0;
            char_count_reg <= '0;
        end
        else if (accept)
        begin
            capturing_reg  <= capturing_next;
            char_count_reg <= char_count_next;
        end
    end

    // frame byte store
    always_ff @(posedge clk)
    begin
        if (accept && store)
        begin
            frame_chars_reg[cnt_eff[1:0]] <= rx.rx_byte;
        end
    end

endmodule

// ===== design/sacd_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacd_queue: command queue
// Small first-in first-out store of decoded commands between the frame
// front and the actuator back.
// ---------------------------------------------------------------------------
module sacd_queue #(
    parameter int DEPTH = sacd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sacd_pkg::cmd_entry_t push_entry,
    output logic                 full,
    output logic                 q_valid,
    output sacd_pkg::cmd_entry_t q_entry,
    input  logic                 pop
);
    import sacd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_entry_t      mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/sacd_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacd_back: command execution and result output
// Pops decoded commands, updates the actuator state and emits one status
// result per frame, or one result per byte of a ball query reply.
// ---------------------------------------------------------------------------
module sacd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  sacd_pkg::cmd_entry_t        q_entry,
    output logic                        q_pop,
    input  logic [sacd_pkg::DUTY_W-1:0] run_duty,
    input  logic [sacd_pkg::DUTY_W-1:0] stop_duty,
    sacd_tx_if.source                   tx
);
    import sacd_pkg::*;

    logic                   out_valid_reg, out_valid_next;
    logic                   reply_active_reg, reply_active_next;
    logic [REPLY_IDX_W-1:0] reply_idx_reg, reply_idx_next;
    logic                   reply_no_reg, reply_no_next;
    logic                   kick_reg, kick_next;
    logic                   charge_reg, charge_next;
    logic [LED_W-1:0]       led_reg, led_next;
    logic [DUTY_W-1:0]      duty_reg, duty_next;

    logic                   txv_reg, txv_next;
    logic [BYTE_W-1:0]      txb_reg, txb_next;
    logic                   last_reg, last_next;

    logic                   can_load;
    logic                   load;

    // next actuator state, reply sequencing and output load
    always_comb
    begin
        can_load          = !out_valid_reg || tx.ready;
        q_pop             = 1'b0;
        load              = 1'b0;
        reply_active_next = reply_active_reg;
        reply_idx_next    = reply_idx_reg;
        reply_no_next     = reply_no_reg;
        kick_next         = kick_reg;
        charge_next       = charge_reg;
        led_next          = led_reg;
        duty_next         = duty_reg;
        txv_next          = 1'b0;
        txb_next          = '0;
        last_next         = 1'b1;

        if (can_load && reply_active_reg)
        begin
            load           = 1'b1;
            txv_next       = 1'b1;
            txb_next       = reply_byte(reply_no_reg, reply_idx_reg);
            last_next      = (reply_idx_reg == reply_last_idx(reply_no_reg));
            reply_idx_next = reply_idx_reg + REPLY_IDX_W'(1);
            if (last_next)
            begin
                reply_active_next = 1'b0;
            end
        end
        else if (can_load && q_valid)
        begin
            q_pop = 1'b1;
            load  = 1'b1;
            unique case (q_entry.cmd)
                CMD_KICK_RUN:
                begin
                    charge_next = 1'b0;
                    kick_next   = 1'b1;
                    led_next    = LED_RUN;
                end
                CMD_KICK_STOP:
                begin
                    charge_next = 1'b0;
                    kick_next   = 1'b0;
                    led_next    = LED_STOP;
                end
                CMD_CHARGE_RUN:
                begin
                    kick_next   = 1'b0;
                    charge_next = 1'b1;
                    led_next    = LED_RUN;
                end
                CMD_CHARGE_STOP:
                begin
                    kick_next   = 1'b0;
                    charge_next = 1'b0;
                    led_next    = LED_STOP;
                end
                CMD_BALL_QUERY:
                begin
                    led_next = LED_RUN;
                end
                CMD_DRIB_RUN:
                begin
                    led_next  = LED_RUN;
                    duty_next = run_duty;
                end
                CMD_DRIB_STOP:
                begin
                    led_next  = LED_STOP;
                    duty_next = stop_duty;
                end
                CMD_NONE:
                begin
                    led_next = led_reg;
                end
            endcase

            // a query starts the reply with its first byte
            if (q_entry.cmd == CMD_BALL_QUERY)
            begin
                txv_next          = 1'b1;
                txb_next          = reply_byte(q_entry.no_ball, '0);
                last_next         = 1'b0;
                reply_active_next = 1'b1;
                reply_idx_next    = REPLY_IDX_W'(1);
                reply_no_next     = q_entry.no_ball;
            end
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control and actuator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            reply_active_reg <= 1'b0;
            reply_idx_reg    <= '0;
            reply_no_reg     <= 1'b0;
            kick_reg         <= 1'b0;
            charge_reg       <= 1'b0;
            led_reg          <= LED_RESET;
            duty_reg         <= DUTY_RESET;
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            reply_active_reg <= reply_active_next;
            reply_idx_reg    <= reply_idx_next;
            reply_no_reg     <= reply_no_next;
            kick_reg         <= kick_next;
            charge_reg       <= charge_next;
            led_reg          <= led_next;
            duty_reg         <= duty_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            txv_reg  <= txv_next;
            txb_reg  <= txb_next;
            last_reg <= last_next;
        end
    end

    assign tx.valid         = out_valid_reg;
    assign tx.kick_drive    = kick_reg;
    assign tx.charge_drive  = charge_reg;
    assign tx.led_select    = led_reg;
    assign tx.dribbler_duty = duty_reg;
    assign tx.tx_valid      = txv_reg;
    assign tx.tx_byte       = txb_reg;
    assign tx.last          = last_reg;

`ifndef SYNTHESIS
    // a reply in progress always has a byte waiting on the output
    a_reply_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
        reply_active_reg |-> out_valid_reg)
        else $error("reply active without a pending result");

    // reply index never runs past the longest reply
    a_reply_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        reply_active_reg |-> (reply_idx_reg <= REPLY_IDX_W'(4)))
        else $error("reply index out of range");

    // no command is popped while a reply is still being sent
    a_no_pop_in_reply: assert property (@(posedge clk) disable iff (!rst_n)
        reply_active_reg |-> !q_pop)
        else $error("command popped during reply");

    // a status result without reply byte is always the final one
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !txv_reg) |-> last_reg)
        else $error("status result not marked last");
`endif

endmodule

// ===== design/serial_actuator_command_decoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_actuator_command_decoder: serial command frame decoder
// Decodes framed two-letter actuator commands from a byte stream, drives
// kick, charge, LED and dribbler duty, and answers ball queries.
//
//   channel | dir | handshake      | payload
//   rx      | in  | valid / ready  | rx_byte, ball_sensor
//   tx      | out | valid / ready  | kick_drive .. dribbler_duty, tx_valid, tx_byte, last
//   cfg     | in  | valid / ready  | index, data (start_char, run duty, stop duty)
//
// A byte is taken in every cycle while the command queue has room.
// A closed frame leaves one result through the registered result output
// of the back end; a ball query leaves four or five results, one per cycle
// while tx is ready, paced by the single result register on tx.
// tx stalls back up through the queue (depth QUEUE_DEPTH) to rx.ready.
// Reset is immediate; no clearing pass; cfg.ready is always high.
// ---------------------------------------------------------------------------
module serial_actuator_command_decoder #(
    parameter int QUEUE_DEPTH = sacd_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    sacd_rx_if.sink    rx,
    sacd_tx_if.source  tx,
    sacd_cfg_if.sink   cfg
);
    import sacd_pkg::*;

    logic [BYTE_W-1:0] start_char_reg;
    logic [DUTY_W-1:0] run_duty_reg;
    logic [DUTY_W-1:0] stop_duty_reg;

    logic              q_full;
    logic              q_push;
    cmd_entry_t        push_entry;
    logic              q_valid;
    cmd_entry_t        q_entry;
    logic              q_pop;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= START_CHAR_RESET;
            run_duty_reg   <= RUN_DUTY_RESET;
            stop_duty_reg  <= STOP_DUTY_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == CFG_START_CHAR)
            begin
                start_char_reg <= cfg.data[BYTE_W-1:0];
            end
            else if (cfg.index == CFG_RUN_DUTY)
            begin
                run_duty_reg <= cfg.data[DUTY_W-1:0];
            end
            else if (cfg.index == CFG_STOP_DUTY)
            begin
                stop_duty_reg <= cfg.data[DUTY_W-1:0];
            end
        end
    end

    // frame capture front end
    sacd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .start_char (start_char_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    // command queue
    sacd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (q_pop)
    );

    // actuator back end
    sacd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .run_duty  (run_duty_reg),
        .stop_duty (stop_duty_reg),
        .tx        (tx)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: serial actuator command decoder testbench
// Drives byte requests with random ball levels and random idle gaps,
// stalls the result channel at random, and checks every result against a
// cycle-free model of the frame decoder and actuator state. The run moves
// through several start byte and dribbler duty settings, the extremes
// among them.
// ---------------------------------------------------------------------------
module tb;
    import sacd_pkg::*;

    // one expected or observed result
    typedef struct packed {
        logic              kick;
        logic              charge;
        logic [LED_W-1:0]  led;
        logic [DUTY_W-1:0] duty;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              last;
    } report_t;

    // frame decoder model plus queue of reports still owed by the block
    class command_tracker;
        logic [BYTE_W-1:0] start_char;
        logic [DUTY_W-1:0] run_duty;
        logic [DUTY_W-1:0] stop_duty;
        bit                open;
        int                count;
        logic [BYTE_W-1:0] held [FRAME_LEN];
        logic              kick;
        logic              charge;
        logic [LED_W-1:0]  led;
        logic [DUTY_W-1:0] duty;
        report_t           owed [$];
        int                mismatches;
        int                used;

        function new();
            start_char = START_CHAR_RESET;
            run_duty   = RUN_DUTY_RESET;
            stop_duty  = STOP_DUTY_RESET;
            open       = 0;
            count      = 0;
            kick       = 0;
            charge     = 0;
            led        = LED_RESET;
            duty       = DUTY_RESET;
            mismatches = 0;
            used       = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_START_CHAR: start_char = value[BYTE_W-1:0];
                CFG_RUN_DUTY:   run_duty   = value;
                CFG_STOP_DUTY:  stop_duty  = value;
                default: ;
            endcase
        endfunction

        function cmd_t letters_to_cmd(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
            case ({a, b})
                "kr":    return CMD_KICK_RUN;
                "ks":    return CMD_KICK_STOP;
                "cr":    return CMD_CHARGE_RUN;
                "cs":    return CMD_CHARGE_STOP;
                "ib":    return CMD_BALL_QUERY;
                "dr":    return CMD_DRIB_RUN;
                "ds":    return CMD_DRIB_STOP;
                default: return CMD_NONE;
            endcase
        endfunction

        function report_t snapshot(logic txv, logic [BYTE_W-1:0] txb, logic fin);
            report_t r;
            r.kick     = kick;
            r.charge   = charge;
            r.led      = led;
            r.duty     = duty;
            r.tx_valid = txv;
            r.tx_byte  = txb;
            r.last     = fin;
            return r;
        endfunction

        // accepted byte request: advance the frame and queue its reports
        function void note_byte(logic [BYTE_W-1:0] c, logic no_ball);
            cmd_t              cmd;
            logic [BYTE_W-1:0] reply [$];
            cmd = CMD_NONE;
            used++;
            // start byte restarts before anything else is looked at
            if (c == start_char) begin
                count = 0;
                open  = 1;
            end
            if (!open)
                return;
            if (c >= PRINT_LO && c <= PRINT_HI && count < FRAME_LEN) begin
                held[count] = c;
                count++;
            end
            if (c != CHAR_CR && c != CHAR_LF)
                return;
            // frame closes
            open = 0;
            if (count >= FRAME_LEN && held[0] == start_char && held[1] == CHAR_COLON)
                cmd = letters_to_cmd(held[2], held[3]);
            count = 0;
            case (cmd)
                CMD_KICK_RUN:    begin charge = 0; kick = 1; led = LED_RUN; end
                CMD_KICK_STOP:   begin charge = 0; kick = 0; led = LED_STOP; end
                CMD_CHARGE_RUN:  begin kick = 0; charge = 1; led = LED_RUN; end
                CMD_CHARGE_STOP: begin kick = 0; charge = 0; led = LED_STOP; end
                CMD_BALL_QUERY:  led = LED_RUN;
                CMD_DRIB_RUN:    begin led = LED_RUN; duty = run_duty; end
                CMD_DRIB_STOP:   begin led = LED_STOP; duty = stop_duty; end
                default: ;
            endcase
            if (cmd != CMD_BALL_QUERY) begin
                owed.push_back(snapshot(1'b0, '0, 1'b1));
                return;
            end
            // ball query answer, one report per reply byte
            if (no_ball) begin
                reply.push_back("n");
                reply.push_back("o");
            end
            else begin
                reply.push_back("y");
                reply.push_back("e");
                reply.push_back("s");
            end
            reply.push_back(CHAR_CR);
            reply.push_back(CHAR_LF);
            foreach (reply[k])
                owed.push_back(snapshot(1'b1, reply[k], k == reply.size() - 1));
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // compare one accepted result with the oldest owed report
        function void check_report(report_t got);
            report_t want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (got.kick !== want.kick) begin
                $display("%0t: kick_drive expected %0d actual %0d", $time, want.kick, got.kick);
                mismatches++;
            end
            if (got.charge !== want.charge) begin
                $display("%0t: charge_drive expected %0d actual %0d",
                         $time, want.charge, got.charge);
                mismatches++;
            end
            if (got.led !== want.led) begin
                $display("%0t: led_select expected %0d actual %0d", $time, want.led, got.led);
                mismatches++;
            end
            if (got.duty !== want.duty) begin
                $display("%0t: dribbler_duty expected %0d actual %0d",
                         $time, want.duty, got.duty);
                mismatches++;
            end
            if (got.tx_valid !== want.tx_valid) begin
                $display("%0t: tx_valid expected %0d actual %0d",
                         $time, want.tx_valid, got.tx_valid);
                mismatches++;
            end
            if (got.tx_byte !== want.tx_byte) begin
                $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, got.tx_byte);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;

    command_tracker book;

    sacd_rx_if  rx_ch ();
    sacd_tx_if  tx_ch ();
    sacd_cfg_if cfg_ch ();

    serial_actuator_command_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch),
        .cfg   (cfg_ch)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: check accepted results, stall at random
    always @(posedge clk)
    begin
        if (rst_n && tx_ch.valid && tx_ch.ready)
            book.check_report({tx_ch.kick_drive, tx_ch.charge_drive, tx_ch.led_select,
                               tx_ch.dribbler_duty, tx_ch.tx_valid, tx_ch.tx_byte,
                               tx_ch.last});
        tx_ch.ready <= quiet || ($urandom_range(99) >= 27);
    end

    // random ball level
    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // random byte, full range or within bounds
    function automatic logic [BYTE_W-1:0] rand_byte(input int lo, input int hi);
        return BYTE_W'($urandom_range(hi, lo));
    endfunction

    // one byte request, with random idle cycles ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] c, input logic no_ball);
        while (!quiet && $urandom_range(99) < 27) begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= c;
        rx_ch.ball_sensor <= no_ball;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        book.note_byte(c, no_ball);
    endtask

    task automatic send_text(input string s, input logic no_ball);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], no_ball);
    endtask

    // wait until every owed report has arrived, then let the block go quiet
    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        book.set_reg(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly well-formed command frames with random content, some noise
    task automatic send_command_mix(input int target);
        logic [15:0] pairs [8];
        logic [15:0] pair;
        int          goal;
        int          guard;
        int          pick;
        pairs = '{"kr", "ks", "cr", "cs", "ib", "dr", "ds", "xx"};
        goal  = book.used + target;
        guard = 0;
        while (book.used < goal && guard < 6 * target) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                pair = pairs[$urandom_range(7)];
                if (pair == "xx")
                    pair = {rand_byte(32, 126), rand_byte(32, 126)};
                send_byte(book.start_char, rand_bit());
                // occasionally a broken colon or a dropped letter
                if ($urandom_range(9) == 0)
                    send_byte(rand_byte(0, 255), rand_bit());
                else
                    send_byte(CHAR_COLON, rand_bit());
                send_byte(pair[15:8], rand_bit());
                if ($urandom_range(12) != 0)
                    send_byte(pair[7:0], rand_bit());
                // sometimes trailing bytes past the fourth
                if ($urandom_range(7) == 0)
                    repeat ($urandom_range(1, 3))
                        send_byte(rand_byte(0, 255), rand_bit());
                send_byte($urandom_range(1) ? CHAR_CR : CHAR_LF, rand_bit());
                guard += 5;
            end
            else if (pick < 86) begin
                send_byte(rand_byte(0, 255), rand_bit());
                guard++;
            end
            else begin
                case ($urandom_range(2))
                    0:       send_byte(CHAR_CR, rand_bit());
                    1:       send_byte(CHAR_LF, rand_bit());
                    default: send_byte(rand_byte(32, 126), rand_bit());
                endcase
                guard++;
            end
        end
        // leave no frame open across a register write
        if (book.open)
            send_byte(CHAR_LF, rand_bit());
    endtask

    // stimulus
    initial
    begin
        logic [BYTE_W-1:0] starts [6];
        logic [DUTY_W-1:0] runs   [6];
        logic [DUTY_W-1:0] stops  [6];
        book  = new();
        quiet = 0;
        starts = '{8'h00, 8'hff, CHAR_CR, PRINT_HI, PRINT_LO, START_CHAR_RESET};
        runs   = '{10'd0, 10'h3ff, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   10'($urandom_range(1023)), 10'($urandom_range(1023))};
        stops  = '{10'h3ff, 10'd0, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   10'($urandom_range(1023)), 10'($urandom_range(1023))};
        rst_n             = 1'b0;
        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = '0;
        rx_ch.ball_sensor = 1'b0;
        tx_ch.ready       = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_START_CHAR;
        cfg_ch.data       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle bytes, kick run, restart mid-frame, long frame,
        // short frame, both ball answers
        send_byte(CHAR_LF, 1'b0);
        send_byte(8'hff, 1'b1);
        send_text("5:kr\r", 1'b0);
        send_text("5:5:ib\n", 1'b0);
        send_text("5:cs", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(CHAR_LF, 1'b1);
        send_text("5:\r", 1'b0);
        send_text("5:ib\r", 1'b1);

        // random with reset settings, then a run of register settings
        send_command_mix(60);
        for (int p = 0; p < 6; p++) begin
            settle();
            write_reg(CFG_START_CHAR, {2'b00, starts[p]});
            write_reg(CFG_RUN_DUTY, runs[p]);
            write_reg(CFG_STOP_DUTY, stops[p]);
            // one stretch with no idling on either side
            quiet = (p == 3);
            send_command_mix(62);
        end
        quiet = 0;
        settle();

        if (book.mismatches == 0 && book.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/sacd_pkg.sv
design/sacd_if.sv
design/sacd_front.sv
design/sacd_queue.sv
design/sacd_back.sv
design/serial_actuator_command_decoder.sv
test/tb.sv
